>>> sv/lea128_pkg.sv
package lea128_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BLOCK_W     = 64;
  localparam int unsigned KEY_INDEX_W = 7;
  localparam int unsigned ROUND_COUNT_DEF = 24;

  localparam logic FUNC_KEY_WRITE = 1'b0;
  localparam logic FUNC_ENCRYPT   = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t x3;
    word_t x2;
    word_t x1;
    word_t x0;
  } lea_block_t;

  function automatic word_t rol9(input word_t v);
    rol9 = {v[WORD_W-10:0], v[WORD_W-1:WORD_W-9]};
  endfunction

  function automatic word_t ror5(input word_t v);
    ror5 = {v[4:0], v[WORD_W-1:5]};
  endfunction

  function automatic word_t ror3(input word_t v);
    ror3 = {v[2:0], v[WORD_W-1:3]};
  endfunction

  // key row packs K0 in the low word up to K3 in the high word
  function automatic lea_block_t lea_round(input lea_block_t x, input lea_block_t k);
    lea_block_t y;
    y.x0 = rol9((x.x0 ^ k.x0) + (x.x1 ^ k.x1));
    y.x1 = ror5((x.x1 ^ k.x2) + (x.x2 ^ k.x1));
    y.x2 = ror3((x.x2 ^ k.x3) + (x.x3 ^ k.x1));
    y.x3 = x.x0;
    lea_round = y;
  endfunction

endpackage

>>> sv/lea128_block_encrypt.sv
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   func, key_index, key_word, block_lo, block_hi
// out_     output     out_valid / out_stall cipher_lo, cipher_hi
//
// The round loop runs one round a cycle up to the last round, one 128-bit key row read a round.
// Round keys sit in a memory of ROUND_COUNT rows of four words, one word written per beat.
// Reset (rst_n low, synchronous) clears control only; key rows stay undefined until written.
// A new item is taken while a finished beat waits on out_stall; the last round holds
// until the output register is free.
module lea128_block_encrypt
  import lea128_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_func,
  input  logic [KEY_INDEX_W-1:0] in_key_index,
  input  logic [WORD_W-1:0]      in_key_word,
  input  logic [BLOCK_W-1:0]     in_block_lo,
  input  logic [BLOCK_W-1:0]     in_block_hi,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [BLOCK_W-1:0]     out_cipher_lo,
  output logic [BLOCK_W-1:0]     out_cipher_hi
);

  localparam int unsigned ROW_W     = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam int unsigned KEY_WORDS = 4 * ROUND_COUNT;
  localparam logic [ROW_W-1:0] LAST_ROUND = ROW_W'(ROUND_COUNT - 1);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t           state_r, state_nxt;
  logic [ROW_W-1:0] round_r, round_nxt;
  lea_block_t       data_r, data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [BLOCK_W-1:0] cipher_lo_r, cipher_lo_nxt;
  logic [BLOCK_W-1:0] cipher_hi_r, cipher_hi_nxt;

  lea_block_t       key_mem [ROUND_COUNT];
  lea_block_t       key_r;
  logic             rd_en;
  logic [ROW_W-1:0] rd_addr;
  logic             wr_en;
  logic [ROW_W-1:0] wr_row;
  logic [1:0]       wr_lane;

  logic       in_accept;
  logic       enc_accept;
  logic       out_free;
  logic       last_round;
  lea_block_t round_out;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign enc_accept = in_accept && (in_func == FUNC_ENCRYPT);
  assign out_free   = !out_valid_r || !out_stall;
  assign last_round = (round_r == LAST_ROUND);
  assign round_out  = lea_round(data_r, key_r);

  assign wr_en   = in_accept && (in_func == FUNC_KEY_WRITE) &&
                   ({1'b0, in_key_index} < (KEY_INDEX_W+1)'(KEY_WORDS));
  assign wr_row  = in_key_index[ROW_W+1:2];
  assign wr_lane = in_key_index[1:0];

  assign rd_en   = enc_accept || ((state_r == ST_RUN) && !last_round);
  assign rd_addr = (state_r == ST_RUN) ? ROW_W'(round_r + 1'b1) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_row][wr_lane*WORD_W +: WORD_W] <= in_key_word;
    end
    if (rd_en) begin
      key_r <= key_mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r;
    cipher_lo_nxt = cipher_lo_r;
    cipher_hi_nxt = cipher_hi_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (enc_accept) begin
          data_nxt  = {in_block_hi, in_block_lo};
          round_nxt = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!last_round) begin
          data_nxt  = round_out;
          round_nxt = ROW_W'(round_r + 1'b1);
        end else if (out_free) begin
          cipher_lo_nxt = {round_out.x1, round_out.x0};
          cipher_hi_nxt = {round_out.x3, round_out.x2};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
    data_r      <= data_nxt;
    cipher_lo_r <= cipher_lo_nxt;
    cipher_hi_r <= cipher_hi_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_cipher_lo = cipher_lo_r;
  assign out_cipher_hi = cipher_hi_r;

  a_enc_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    enc_accept |=> (state_r == ST_RUN) && (round_r == '0))
    else $error("encrypt beat did not start round 0");

  a_round_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && !last_round |=> (round_r == ROW_W'($past(round_r) + 1'b1)))
    else $error("round counter did not advance");

  a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (round_r <= LAST_ROUND))
    else $error("round counter beyond last round");

  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RUN) && (state_r == ST_IDLE))
    else $error("result beat raised outside the last round");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(cipher_lo_r) && $stable(cipher_hi_r))
    else $error("waiting result beat overwritten");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import lea128_pkg::*;

  localparam int unsigned ROUNDS    = ROUND_COUNT_DEF;
  localparam int unsigned KEY_WORDS = 4 * ROUNDS;

  typedef struct packed {
    logic                   func;
    logic [KEY_INDEX_W-1:0] idx;
    logic [WORD_W-1:0]      kw;
    logic [BLOCK_W-1:0]     lo;
    logic [BLOCK_W-1:0]     hi;
  } lea_item_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] lo;
    logic [BLOCK_W-1:0] hi;
  } cipher_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                   clk          = 1'b0;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic                   in_func      = FUNC_KEY_WRITE;
  logic [KEY_INDEX_W-1:0] in_key_index = '0;
  logic [WORD_W-1:0]      in_key_word  = '0;
  logic [BLOCK_W-1:0]     in_block_lo  = '0;
  logic [BLOCK_W-1:0]     in_block_hi  = '0;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic [BLOCK_W-1:0]     out_cipher_lo;
  logic [BLOCK_W-1:0]     out_cipher_hi;

  word_t       round_keys [KEY_WORDS];
  lea_item_t   beat_q[$];
  cipher_t     cipher_q[$];
  lea_item_t   drv_item;
  cipher_t     got_c;
  cipher_t     exp_c;
  int          burst_left   = 0;
  int          gap_left     = 0;
  int          mismatches   = 0;
  int          results_seen = 0;
  int          hold_left    = 0;
  bit          hold_done    = 1'b0;
  int          mode_left    = 0;
  int          cyc          = 0;
  stall_mode_t stall_mode   = STALL_NONE;

  lea128_block_encrypt i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_key_index  (in_key_index),
    .in_key_word   (in_key_word),
    .in_block_lo   (in_block_lo),
    .in_block_hi   (in_block_hi),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cipher_lo (out_cipher_lo),
    .out_cipher_hi (out_cipher_hi)
  );

  always #5 clk = ~clk;

  function automatic cipher_t lea_encrypt(input logic [BLOCK_W-1:0] lo,
                                          input logic [BLOCK_W-1:0] hi);
    word_t   x0, x1, x2, x3, n0, n1, n2, t, k0, k1, k2, k3;
    cipher_t c;
    x0 = lo[31:0];
    x1 = lo[63:32];
    x2 = hi[31:0];
    x3 = hi[63:32];
    for (int r = 0; r < ROUNDS; r++) begin
      k0 = round_keys[4*r];
      k1 = round_keys[4*r+1];
      k2 = round_keys[4*r+2];
      k3 = round_keys[4*r+3];
      t  = (x0 ^ k0) + (x1 ^ k1);
      n0 = {t[22:0], t[31:23]};
      t  = (x1 ^ k2) + (x2 ^ k1);
      n1 = {t[4:0], t[31:5]};
      t  = (x2 ^ k3) + (x3 ^ k1);
      n2 = {t[2:0], t[31:3]};
      x3 = x0;
      x0 = n0;
      x1 = n1;
      x2 = n2;
    end
    c.lo = {x1, x0};
    c.hi = {x3, x2};
    return c;
  endfunction

  task automatic track_beat(input lea_item_t it);
    if (it.func == FUNC_ENCRYPT) begin
      cipher_q.push_back(lea_encrypt(it.lo, it.hi));
    end else if (it.idx < KEY_WORDS) begin
      round_keys[it.idx] = it.kw;
    end
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [BLOCK_W-1:0] rand_block();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void push_beat(input logic func, input int idx, input word_t kw,
                                    input logic [BLOCK_W-1:0] lo,
                                    input logic [BLOCK_W-1:0] hi);
    lea_item_t it;
    it.func = func;
    it.idx  = KEY_INDEX_W'(idx);
    it.kw   = kw;
    it.lo   = lo;
    it.hi   = hi;
    beat_q.push_back(it);
  endfunction

  task automatic push_random(input int n);
    int cnt;
    int sel;
    cnt = 0;
    while (cnt < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        push_beat(FUNC_ENCRYPT, $urandom_range(0, 127), rand_word(), rand_block(),
                  rand_block());
        cnt++;
      end else if (sel < 95) begin
        push_beat(FUNC_KEY_WRITE, $urandom_range(0, KEY_WORDS-1), rand_word(),
                  rand_block(), rand_block());
        cnt++;
      end else begin
        // out-of-range index: ignored by the block
        push_beat(FUNC_KEY_WRITE, $urandom_range(KEY_WORDS, 127), rand_word(),
                  rand_block(), rand_block());
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (beat_q.size() != 0 || in_valid || cipher_q.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_beat({in_func, in_key_index, in_key_word, in_block_lo, in_block_hi});
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          drv_item = beat_q.pop_front();
          in_func      <= drv_item.func;
          in_key_index <= drv_item.idx;
          in_key_word  <= drv_item.kw;
          in_block_lo  <= drv_item.lo;
          in_block_hi  <= drv_item.hi;
          in_valid     <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      got_c.lo = out_cipher_lo;
      got_c.hi = out_cipher_hi;
      if (cipher_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result lo=%h hi=%h", got_c.lo, got_c.hi);
        end
      end else begin
        exp_c = cipher_q.pop_front();
        if (got_c.lo !== exp_c.lo || got_c.hi !== exp_c.hi) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected lo=%h hi=%h, got lo=%h hi=%h",
                     results_seen, exp_c.lo, exp_c.hi, got_c.lo, got_c.hi);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (!hold_done && results_seen == 100) begin
      // long hold-off: let the block back up onto its input
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((cyc % 7) < 3);
      endcase
    end
  end

  initial begin
    #(10_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole key store before any encrypt
    for (int i = 0; i < KEY_WORDS; i++) begin
      push_beat(FUNC_KEY_WRITE, i, rand_word(), rand_block(), rand_block());
    end

    push_beat(FUNC_ENCRYPT, 0, '0, '0, '0);
    push_beat(FUNC_ENCRYPT, 0, '0, '1, '1);
    push_beat(FUNC_ENCRYPT, 0, '0, '1, '0);
    push_beat(FUNC_ENCRYPT, 0, '0, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    push_beat(FUNC_ENCRYPT, 0, '0, 64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908);
    push_beat(FUNC_KEY_WRITE, KEY_WORDS, '1, '1, '1);
    push_beat(FUNC_KEY_WRITE, 127, '0, '1, '1);
    push_beat(FUNC_ENCRYPT, 0, '0, '0, '0);
    push_beat(FUNC_KEY_WRITE, 0, '0, '1, '1);
    push_beat(FUNC_KEY_WRITE, KEY_WORDS-1, '1, '1, '1);
    push_beat(FUNC_ENCRYPT, 127, '1, '1, '1);
    for (int i = 4; i < 8; i++) begin
      push_beat(FUNC_KEY_WRITE, i, '1, '0, '0);
    end
    push_beat(FUNC_ENCRYPT, 0, '0, '1, '1);
    push_beat(FUNC_ENCRYPT, 85, 32'h5555_5555, 64'h8000_0000_8000_0000,
              64'h0000_0001_0000_0001);
    push_beat(FUNC_KEY_WRITE, 42, 32'h8000_0001, '0, '0);
    push_beat(FUNC_ENCRYPT, 0, '0, 64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff);
    wait_drained();

    push_random(700);
    wait_drained();

    push_random(800);
    wait_drained();

    repeat (60) @(posedge clk);
    if (mismatches == 0 && cipher_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (cipher_q.size() != 0) begin
        $display("%0d results never arrived", cipher_q.size());
      end
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> lea128_block_encrypt.f
sv/lea128_pkg.sv
sv/lea128_block_encrypt.sv
tb/tb_top.sv
